### rtl/btcd_pkg.sv
// btcd_pkg: shared types, register codes and constants of the button tap chord decoder.
// No dependencies; used by btcd_modifier and button_tap_chord_decoder.
`default_nettype none

package btcd_pkg;

   // configuration register map
   localparam int unsigned CSR_INDEX_WIDTH = 2;
   localparam int unsigned CSR_DATA_WIDTH  = 16;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_TAP_LIMIT     = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_DOUBLE_WINDOW = 2'd1;

   localparam logic [CSR_DATA_WIDTH-1:0] TAP_LIMIT_RESET     = 16'd300;
   localparam logic [CSR_DATA_WIDTH-1:0] DOUBLE_WINDOW_RESET = 16'd350;

   // since-tap timers start here (or at the time maximum if that is smaller)
   localparam int unsigned SINCE_RESET_MS = 10000;
   localparam int unsigned SINCE_RESET_BITS = 14;

   localparam int unsigned ELAPSED_WIDTH = 10;
   localparam int unsigned AXIS_WIDTH    = 2;

   typedef logic signed [AXIS_WIDTH-1:0] axis_type;

   // tap event of one modifier on one tick
   typedef struct packed {
      logic tap;   // single or double
      logic dbl;   // double only
   } mod_event_type;

   // positive key minus negative key
   function automatic axis_type axis_of(input logic pos, input logic neg);
      axis_type result;
      result = '0;
      if (pos && !neg) begin
         result = 2'sb01;
      end else if (neg && !pos) begin
         result = 2'sb11;
      end
      return result;
   endfunction

endpackage

`default_nettype wire

### rtl/button_tap_chord_decoder.sv
// button_tap_chord_decoder: top level of the pad tap and chord decoder.
// Depends on btcd_pkg and btcd_modifier.
`default_nettype none

// Usage
//  - req_* channel: one item per tick, eight button levels plus the
//    milliseconds since the previous tick. Taken when req_valid is high and
//    req_stall is low.
//  - rsp_* channel: exactly one result item per request item, in order.
//    Delivered when rsp_valid is high and rsp_stall is low.
//  - csr_* channel: register writes (index 0 tap limit, 1 double window).
//    csr_ready is always high; unknown indexes are dropped. Write only while
//    no item is in flight.
//  - Registering: the result is registered in the cycle the item is taken, so
//    it shows on rsp_* in the cycle after acceptance.
//  - Throughput: one item per cycle while rsp_stall is low. All tick work
//    (axis routing, saturating timer adds, tap compares, pending countdown)
//    is one pass of logic from the request ports into the result register.
//  - Stall: the single result register holds while full and rsp_stall is high;
//    req_stall is raised only while that register is full and stalled.
//  - Reset: synchronous, active high. Registers return to their reset
//    values, timers restart, the result register empties.
module button_tap_chord_decoder #(
   parameter int unsigned TIME_WIDTH = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,

   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic                                  req_key_up,
   input  wire logic                                  req_key_down,
   input  wire logic                                  req_key_left,
   input  wire logic                                  req_key_right,
   input  wire logic                                  req_left_modifier,
   input  wire logic                                  req_right_modifier,
   input  wire logic                                  req_key_fire,
   input  wire logic                                  req_key_second,
   input  wire logic [btcd_pkg::ELAPSED_WIDTH-1:0]    req_elapsed_ms,

   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic signed [btcd_pkg::AXIS_WIDTH-1:0]     rsp_yaw_axis,
   output logic signed [btcd_pkg::AXIS_WIDTH-1:0]     rsp_roll_axis,
   output logic signed [btcd_pkg::AXIS_WIDTH-1:0]     rsp_pitch_axis,
   output logic signed [btcd_pkg::AXIS_WIDTH-1:0]     rsp_throttle_step,
   output logic                                       rsp_cycle_pulse,
   output logic                                       rsp_boost_pulse,
   output logic                                       rsp_assist_pulse,
   output logic                                       rsp_fire_level,
   output logic                                       rsp_second_pulse,

   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [btcd_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire logic [btcd_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);

   localparam int unsigned WW = ((TIME_WIDTH > 16) ? TIME_WIDTH : 16) + 1;
   localparam logic [WW-1:0] TIME_MAX_W = {{(WW-TIME_WIDTH){1'b0}}, {TIME_WIDTH{1'b1}}};

   // ---------------------------------------------------------------------
   // handshake
   // ---------------------------------------------------------------------
   logic accept;
   logic rsp_valid_ff, rsp_valid_in;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign csr_ready = 1'b1;

   // ---------------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------------
   logic [btcd_pkg::CSR_DATA_WIDTH-1:0] tap_limit_ff;
   logic [btcd_pkg::CSR_DATA_WIDTH-1:0] double_window_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_limit_ff     <= btcd_pkg::TAP_LIMIT_RESET;
         double_window_ff <= btcd_pkg::DOUBLE_WINDOW_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            btcd_pkg::REG_TAP_LIMIT:     tap_limit_ff     <= csr_wdata;
            btcd_pkg::REG_DOUBLE_WINDOW: double_window_ff <= csr_wdata;
            default: ;                   // unknown index: dropped
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // modifier tap detectors
   // ---------------------------------------------------------------------
   logic                    left_held, right_held;
   btcd_pkg::mod_event_type left_event, right_event;
   logic                    dpad_any;

   assign dpad_any = req_key_up | req_key_down | req_key_left | req_key_right;

   btcd_modifier #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_left_mod (
      .clock         (clock),
      .reset         (reset),
      .step          (accept),
      .level         (req_left_modifier),
      .consume_now   (1'b0),            // left press is never consumed
      .elapsed       (req_elapsed_ms),
      .tap_limit     (tap_limit_ff),
      .double_window (double_window_ff),
      .held          (left_held),
      .event_out     (left_event)
   );

   btcd_modifier #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_right_mod (
      .clock         (clock),
      .reset         (reset),
      .step          (accept),
      .level         (req_right_modifier),
      .consume_now   (dpad_any),        // d-pad use during the press eats the tap
      .elapsed       (req_elapsed_ms),
      .tap_limit     (tap_limit_ff),
      .double_window (double_window_ff),
      .held          (right_held),
      .event_out     (right_event)
   );

   // ---------------------------------------------------------------------
   // deferred right single tap
   // ---------------------------------------------------------------------
   logic                  pending_armed_ff, pending_armed_in;
   logic [TIME_WIDTH-1:0] pending_remaining_ff, pending_remaining_in;
   logic [WW-1:0]         window_w;
   logic [WW-1:0]         elapsed_w;
   logic                  assist;

   always_comb begin
      window_w  = {{(WW-btcd_pkg::CSR_DATA_WIDTH){1'b0}}, double_window_ff};
      elapsed_w = {{(WW-btcd_pkg::ELAPSED_WIDTH){1'b0}}, req_elapsed_ms};

      pending_armed_in     = pending_armed_ff;
      pending_remaining_in = pending_remaining_ff;
      assist               = 1'b0;

      if (right_event.dbl) begin
         pending_armed_in = 1'b0;               // double cancels the single
      end else if (right_event.tap) begin
         pending_armed_in     = 1'b1;
         pending_remaining_in = (window_w > TIME_MAX_W) ? {TIME_WIDTH{1'b1}}
                                                        : window_w[TIME_WIDTH-1:0];
      end else if (pending_armed_ff) begin
         if (elapsed_w > {{(WW-TIME_WIDTH){1'b0}}, pending_remaining_ff}) begin
            assist               = 1'b1;
            pending_armed_in     = 1'b0;
            pending_remaining_in = '0;
         end else begin
            pending_remaining_in = pending_remaining_ff - elapsed_w[TIME_WIDTH-1:0];
         end
      end
   end

   logic previous_second_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_armed_ff     <= 1'b0;
         pending_remaining_ff <= '0;
         previous_second_ff   <= 1'b0;
      end else if (accept) begin
         pending_armed_ff     <= pending_armed_in;
         pending_remaining_ff <= pending_remaining_in;
         previous_second_ff   <= req_key_second;
      end
   end

   // ---------------------------------------------------------------------
   // result register
   // ---------------------------------------------------------------------
   btcd_pkg::axis_type lr_axis, ud_axis;
   btcd_pkg::axis_type yaw_in, roll_in, pitch_in, throttle_in;
   logic               boost_in;

   // routing uses the modifier state from before this tick
   always_comb begin
      lr_axis     = btcd_pkg::axis_of(req_key_right, req_key_left);
      ud_axis     = btcd_pkg::axis_of(req_key_up, req_key_down);
      yaw_in      = left_held  ? '0 : lr_axis;
      roll_in     = left_held  ? lr_axis : '0;
      pitch_in    = right_held ? '0 : ud_axis;
      throttle_in = right_held ? ud_axis : '0;
      boost_in    = right_event.dbl;
   end

   btcd_pkg::axis_type yaw_ff, roll_ff, pitch_ff, throttle_ff;
   logic cycle_ff, boost_ff, assist_ff, fire_ff, second_ff;

   assign rsp_valid_in = accept | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         yaw_ff      <= yaw_in;
         roll_ff     <= roll_in;
         pitch_ff    <= pitch_in;
         throttle_ff <= throttle_in;
         cycle_ff    <= left_event.tap;
         boost_ff    <= boost_in;
         assist_ff   <= assist;
         fire_ff     <= req_key_fire;
         second_ff   <= req_key_second & ~previous_second_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_yaw_axis      = yaw_ff;
   assign rsp_roll_axis     = roll_ff;
   assign rsp_pitch_axis    = pitch_ff;
   assign rsp_throttle_step = throttle_ff;
   assign rsp_cycle_pulse   = cycle_ff;
   assign rsp_boost_pulse   = boost_ff;
   assign rsp_assist_pulse  = assist_ff;
   assign rsp_fire_level    = fire_ff;
   assign rsp_second_pulse  = second_ff;

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------
   a_boost_assist_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_boost_pulse && rsp_assist_pulse))
      else $error("boost and assist in the same item");

   a_assist_needs_pending: assert property (@(posedge clock) disable iff (reset)
      (accept && !pending_armed_ff) |=> !rsp_assist_pulse)
      else $error("assist without an armed single");

   a_boost_disarms: assert property (@(posedge clock) disable iff (reset)
      (accept && boost_in) |=> !pending_armed_ff)
      else $error("pending single survived a double tap");

   a_lr_routed_once: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_yaw_axis == '0 || rsp_roll_axis == '0))
      else $error("left/right pair routed to yaw and roll at once");

endmodule

`default_nettype wire

### rtl/btcd_modifier.sv
// btcd_modifier: press/hold/release tap detector for one shoulder modifier.
// Depends on btcd_pkg.
`default_nettype none

module btcd_modifier #(
   parameter int unsigned TIME_WIDTH = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   step,
   input  wire logic                                   level,
   input  wire logic                                   consume_now,
   input  wire logic [btcd_pkg::ELAPSED_WIDTH-1:0]     elapsed,
   input  wire logic [btcd_pkg::CSR_DATA_WIDTH-1:0]    tap_limit,
   input  wire logic [btcd_pkg::CSR_DATA_WIDTH-1:0]    double_window,
   output logic                                        held,
   output btcd_pkg::mod_event_type                     event_out
);

   // wide enough for any sum and for the 16-bit registers, with a carry bit
   localparam int unsigned WW = ((TIME_WIDTH > 16) ? TIME_WIDTH : 16) + 1;
   localparam logic [WW-1:0] TIME_MAX_W = {{(WW-TIME_WIDTH){1'b0}}, {TIME_WIDTH{1'b1}}};
   localparam logic [TIME_WIDTH-1:0] SINCE_RESET =
      (TIME_WIDTH >= btcd_pkg::SINCE_RESET_BITS) ?
         TIME_WIDTH'(btcd_pkg::SINCE_RESET_MS) : {TIME_WIDTH{1'b1}};

   logic                  held_ff,     held_in;
   logic                  consumed_ff, consumed_in;
   logic [TIME_WIDTH-1:0] hold_ff,     hold_in;
   logic [TIME_WIDTH-1:0] since_ff,    since_in;

   logic [TIME_WIDTH-1:0] since_sum;
   logic [TIME_WIDTH-1:0] hold_base;
   logic [TIME_WIDTH-1:0] hold_sum;
   logic                  is_tap;
   logic                  is_dbl;

   function automatic logic [TIME_WIDTH-1:0] sat_add(
      input logic [TIME_WIDTH-1:0]              a,
      input logic [btcd_pkg::ELAPSED_WIDTH-1:0] b
   );
      logic [WW-1:0] sum;
      sum = {{(WW-TIME_WIDTH){1'b0}}, a} + {{(WW-btcd_pkg::ELAPSED_WIDTH){1'b0}}, b};
      return (sum > TIME_MAX_W) ? {TIME_WIDTH{1'b1}} : sum[TIME_WIDTH-1:0];
   endfunction

   always_comb begin
      since_sum = sat_add(since_ff, elapsed);
      hold_base = held_ff ? hold_ff : '0;     // press tick restarts the hold
      hold_sum  = sat_add(hold_base, elapsed);

      is_tap = !level && held_ff && !consumed_ff &&
               ({{(WW-TIME_WIDTH){1'b0}}, hold_ff} <
                {{(WW-btcd_pkg::CSR_DATA_WIDTH){1'b0}}, tap_limit});
      is_dbl = is_tap &&
               ({{(WW-TIME_WIDTH){1'b0}}, since_sum} <
                {{(WW-btcd_pkg::CSR_DATA_WIDTH){1'b0}}, double_window});

      held_in     = level;
      hold_in     = level ? hold_sum : hold_ff;
      consumed_in = level ? ((held_ff & consumed_ff) | consume_now) : consumed_ff;
      since_in    = is_tap ? '0 : since_sum;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff     <= 1'b0;
         consumed_ff <= 1'b0;
         hold_ff     <= '0;
         since_ff    <= SINCE_RESET;
      end else if (step) begin
         held_ff     <= held_in;
         consumed_ff <= consumed_in;
         hold_ff     <= hold_in;
         since_ff    <= since_in;
      end
   end

   assign held          = held_ff;
   assign event_out.tap = is_tap;
   assign event_out.dbl = is_dbl;

endmodule

`default_nettype wire
